>>> hw/rtl/fpba_pkg.sv
`default_nettype none

package fpba_pkg;

  // Default sizes of the block table.
  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  // Allocation policies. The unused fourth code behaves as first fit.
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // Input beat kinds, carried on the input tuser bit.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_FIT_POLICY    = 1'b0;
  localparam logic CFG_ACTIVE_BLOCKS = 1'b1;

  // Field widths of the configuration registers and the stream payload.
  localparam int POLICY_W      = 2;
  localparam int ACTIVE_W      = 5;
  localparam int CFG_DATA_W    = 5;
  localparam int BLK_FIELD_W   = 4;
  localparam int SIZE_FIELD_W  = 16;
  localparam int TDATA_W       = 24;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  // Control bits of the search token that walks along the cell chain.
  typedef struct packed {
    logic valid;
    logic found;
  } scan_ctl_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

>>> hw/rtl/fpba_cell.sv
`default_nettype none

// One table entry. It holds the free size of its block and, when the search
// token passes, updates the best candidate before handing the token on.
module fpba_cell #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF,
  parameter int INDEX      = 0,
  localparam int IdxW      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Broadcast search settings; the user must keep them stable while a search runs, the block does not enforce it.
  input  wire logic [fpba_pkg::POLICY_W-1:0]     policy_i,
  input  wire logic [fpba_pkg::ACTIVE_W-1:0]     active_i,
  input  wire logic [SIZE_BITS-1:0]              req_i,
  // Broadcast table write.
  input  wire logic                              wr_en_i,
  input  wire logic [IdxW-1:0]                   wr_idx_i,
  input  wire logic [SIZE_BITS-1:0]              wr_data_i,
  // Token from the left neighbor.
  input  wire fpba_pkg::scan_ctl_t               tok_ctl_i,
  input  wire logic [IdxW-1:0]                   tok_pick_i,
  input  wire logic [SIZE_BITS-1:0]              tok_size_i,
  // Token to the right neighbor.
  output fpba_pkg::scan_ctl_t                    tok_ctl_o,
  output logic [IdxW-1:0]                        tok_pick_o,
  output logic [SIZE_BITS-1:0]                   tok_size_o
);
  import fpba_pkg::*;

  localparam int CmpW = (IdxW + 1 > ACTIVE_W) ? IdxW + 1 : ACTIVE_W;

  logic [SIZE_BITS-1:0] size_q;
  logic                 in_range;
  logic                 fits;
  logic                 take;
  scan_ctl_t            ctl_q;
  logic [IdxW-1:0]      pick_q;
  logic [SIZE_BITS-1:0] best_q;

  // Entry storage, written by loads and by the grant write-back.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == IdxW'(INDEX))) begin
      size_q <= wr_data_i;
    end
  end

  // Decide whether this entry replaces the candidate carried by the token.
  always_comb begin
    in_range = CmpW'(INDEX) < CmpW'(active_i);
    fits     = size_q >= req_i;
    take     = 1'b0;
    if (tok_ctl_i.valid && in_range && fits) begin
      if (!tok_ctl_i.found) begin
        take = 1'b1;
      end else if (policy_i == FIT_BEST) begin
        take = size_q < tok_size_i;
      end else if (policy_i == FIT_WORST) begin
        take = size_q > tok_size_i;
      end
    end
  end

  // Token control stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q.valid <= tok_ctl_i.valid;
      ctl_q.found <= tok_ctl_i.found | take;
    end
  end

  // Token payload stage.
  always_ff @(posedge clk_i) begin
    pick_q <= take ? IdxW'(INDEX) : tok_pick_i;
    best_q <= take ? size_q : tok_size_i;
  end

  assign tok_ctl_o  = ctl_q;
  assign tok_pick_o = pick_q;
  assign tok_size_o = best_q;

endmodule

`default_nettype wire

>>> hw/rtl/fit_policy_block_allocator.sv
`default_nettype none

// Block allocator with a first, best or worst fit policy.
// Input stream: one beat per item. tuser selects a load (0) or an allocate
// (1). A load writes a block's free size into the table and gives no
// result. An allocate sends a search token down a chain of NUM_BLOCKS
// cells, one cell per cycle, and the block takes no next input beat until
// the search is through and its result has moved to the output register.
// Output stream: one beat per allocate, with the grant flag on tuser and the
// chosen block and remaining size on tdata; both are zero when nothing fits.
// The chosen entry is reduced by the request size through the registered
// table write command once the token leaves the chain, before the next input
// beat can be taken. The result sits in an output register, so a new input
// beat is taken while it waits; a stalled receiver holds the block only when
// the next result is ready and the register is still full.
// Reset clears the policy to first fit, the active count to 16 and all
// handshake state; table entries hold no value until loaded. Configuration:
// register 0 is the policy, register 1 the active count; the user must write
// them only while idle, as the block itself does not enforce it.
module fit_policy_block_allocator #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write port.
  input  wire logic                            cfg_wr_en_i,
  input  wire logic                            cfg_addr_i,
  input  wire logic [fpba_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Input stream.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata from bit 0: block_index[3:0], size_value[19:4], zero fill.
  input  wire logic [fpba_pkg::TDATA_W-1:0]    s_axis_tdata,
  // tuser: action.
  input  wire logic                            s_axis_tuser,
  // Output stream.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata from bit 0: chosen_block[3:0], remaining_after[19:4], zero fill.
  output logic [fpba_pkg::TDATA_W-1:0]         m_axis_tdata,
  // tuser: granted.
  output logic                                 m_axis_tuser
);
  import fpba_pkg::*;

  localparam int IdxW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  // Configuration registers.
  logic [POLICY_W-1:0] policy_q;
  logic [ACTIVE_W-1:0] active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= FIT_FIRST;
      active_q <= ACTIVE_RESET;
    end else if (cfg_wr_en_i) begin
      case (cfg_addr_i)
        CFG_FIT_POLICY:    policy_q <= cfg_wdata_i[POLICY_W-1:0];
        CFG_ACTIVE_BLOCKS: active_q <= cfg_wdata_i[ACTIVE_W-1:0];
        default:           ;
      endcase
    end
  end

  // Input beat decode.
  logic                    in_beat;
  logic [BLK_FIELD_W-1:0]  in_blk;
  logic [SIZE_BITS-1:0]    in_size;
  logic                    in_blk_ok;

  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign in_blk    = s_axis_tdata[BLK_FIELD_W-1:0];
  assign in_size   = SIZE_BITS'(s_axis_tdata[BLK_FIELD_W +: SIZE_FIELD_W]);
  assign in_blk_ok = 9'(in_blk) < 9'(NUM_BLOCKS);

  // Cell chain. Position 0 is the launched token, the last one leaves it.
  scan_ctl_t            ctl_chain  [NUM_BLOCKS+1];
  logic [IdxW-1:0]      pick_chain [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] size_chain [NUM_BLOCKS+1];

  logic                 launch_q;
  logic [SIZE_BITS-1:0] req_q;
  logic                 wr_en_q;
  logic [IdxW-1:0]      wr_idx_q;
  logic [SIZE_BITS-1:0] wr_data_q;

  assign ctl_chain[0].valid = launch_q;
  assign ctl_chain[0].found = 1'b0;
  assign pick_chain[0]      = '0;
  assign size_chain[0]      = '0;

  for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
    fpba_cell #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS),
      .INDEX      (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .policy_i   (policy_q),
      .active_i   (active_q),
      .req_i      (req_q),
      .wr_en_i    (wr_en_q),
      .wr_idx_i   (wr_idx_q),
      .wr_data_i  (wr_data_q),
      .tok_ctl_i  (ctl_chain[g]),
      .tok_pick_i (pick_chain[g]),
      .tok_size_i (size_chain[g]),
      .tok_ctl_o  (ctl_chain[g+1]),
      .tok_pick_o (pick_chain[g+1]),
      .tok_size_o (size_chain[g+1])
    );
  end

  scan_ctl_t            exit_ctl;
  logic [IdxW-1:0]      exit_pick;
  logic [SIZE_BITS-1:0] exit_size;
  logic [SIZE_BITS-1:0] exit_rem;

  assign exit_ctl  = ctl_chain[NUM_BLOCKS];
  assign exit_pick = pick_chain[NUM_BLOCKS];
  assign exit_size = size_chain[NUM_BLOCKS];
  assign exit_rem  = exit_size - req_q;

  // Sequencer.
  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_load;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_beat && (s_axis_tuser == ACT_ALLOC)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (exit_ctl.valid) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = state_q == ST_IDLE;
    out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Token launch and table write command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= 1'b0;
      wr_en_q  <= 1'b0;
    end else begin
      launch_q <= in_beat && (s_axis_tuser == ACT_ALLOC);
      wr_en_q  <= (in_beat && (s_axis_tuser == ACT_LOAD) && in_blk_ok)
                  || (exit_ctl.valid && exit_ctl.found);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      req_q     <= in_size;
      wr_idx_q  <= IdxW'(in_blk);
      wr_data_q <= in_size;
    end else if (exit_ctl.valid) begin
      wr_idx_q  <= exit_pick;
      wr_data_q <= exit_rem;
    end
  end

  // Result capture as the token leaves the chain.
  logic                    res_grant_q;
  logic [BLK_FIELD_W-1:0]  res_blk_q;
  logic [SIZE_FIELD_W-1:0] res_rem_q;

  always_ff @(posedge clk_i) begin
    if (exit_ctl.valid) begin
      res_grant_q <= exit_ctl.found;
      res_blk_q   <= exit_ctl.found ? BLK_FIELD_W'(exit_pick) : '0;
      res_rem_q   <= exit_ctl.found ? SIZE_FIELD_W'(exit_rem) : '0;
    end
  end

  // Output register.
  logic                    out_grant_q;
  logic [BLK_FIELD_W-1:0]  out_blk_q;
  logic [SIZE_FIELD_W-1:0] out_rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_grant_q <= res_grant_q;
      out_blk_q   <= res_blk_q;
      out_rem_q   <= res_rem_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_grant_q;
  assign m_axis_tdata  = {(TDATA_W - BLK_FIELD_W - SIZE_FIELD_W)'(0), out_rem_q, out_blk_q};

  // A token only leaves the chain while a search is running.
  a_exit_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_ctl.valid |-> (state_q == ST_SCAN))
    else $error("search token left the chain outside a search");

  // A token is launched only after an allocate beat.
  a_launch_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_q |-> $past(in_beat && (s_axis_tuser == ACT_ALLOC)))
    else $error("search launched without an allocate beat");

  // A granted candidate always covers the request.
  a_grant_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exit_ctl.valid && exit_ctl.found) |-> (exit_size >= req_q))
    else $error("granted block is smaller than the request");

  // A refused request carries zero data.
  a_refuse_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("refused request carries nonzero data");

  // Input is never taken while a search is in flight.
  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (launch_q || exit_ctl.valid) |-> !s_axis_tready)
    else $error("input taken during a search");

endmodule

`default_nettype wire
